/* hdl/barometric_sensor_compensation_macros.svh */
// Assertion macros shared by the compensation RTL.
`ifndef BAROMETRIC_SENSOR_COMPENSATION_MACROS_SVH
`define BAROMETRIC_SENSOR_COMPENSATION_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define BSC_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled in reset.
`define BSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* hdl/bsc_pkg.sv */
// Types and constants of the barometric compensation block.
package bsc_pkg;

  localparam int TDIV_W = 27;  // |mc*2048| fits 27 bits
  localparam int PDIV_W = 32;  // unsigned 32-bit pressure quotient
  localparam int CFG_W  = 64;

  localparam logic signed [31:0] C_B6_BIAS  = 32'sd4000;
  localparam logic signed [31:0] C_P_K1     = 32'sd3038;
  localparam logic signed [31:0] C_P_K2     = -32'sd7357;
  localparam logic signed [31:0] C_P_K3     = 32'sd3791;
  localparam logic [31:0]        C_B7_K     = 32'd50000;
  localparam logic [31:0]        C_B7_BIG   = 32'h8000_0000;
  localparam logic signed [31:0] C_B4_BIAS  = 32'sd32768;
  localparam logic signed [33:0] C_PA_MAX   = 34'sd1048575;

  typedef enum logic [2:0] {
    REG_TEMP_CAL   = 3'd0,
    REG_PCAL_A     = 3'd1,
    REG_PCAL_B     = 3'd2,
    REG_OSS        = 3'd3,
    REG_P_OFFSET   = 3'd4
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_TDIV = 2'd1,
    ST_BDIV = 2'd2
  } status_t;

  typedef struct packed {
    logic [15:0] raw_temperature;
    logic [23:0] raw_pressure;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] temperature_tenths;
    logic [19:0]        pressure_pa;
    logic [1:0]         status;
  } out_item_t;

  // sideband riding through the temperature divider
  typedef struct packed {
    logic signed [16:0] x1;
    logic [18:0]        up;
    logic               neg;
    logic               dz;
  } tdiv_side_t;

  // sideband riding through the pressure divider
  typedef struct packed {
    logic signed [15:0] t;
    logic               dz;
    logic               bz;
    logic               big;
  } pdiv_side_t;

endpackage

/* hdl/bsc_stream_if.sv */
// Valid/ready stream interface used for both channels.
interface bsc_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* hdl/bsc_div_cell.sv */
// One restoring-division step: one quotient bit per cell.
module bsc_div_cell import bsc_pkg::*; #(
  parameter int W = PDIV_W,
  parameter type side_t = logic
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic         v_in,
  input  logic [W-1:0] r_in,
  input  logic [W-1:0] nq_in,
  input  logic [W-1:0] d_in,
  input  side_t        side_in,
  output logic         v_out,
  output logic [W-1:0] r_out,
  output logic [W-1:0] nq_out,
  output logic [W-1:0] d_out,
  output side_t        side_out
);

  logic [W:0]   trial;
  logic [W:0]   diff;
  logic         ge;

  always_comb begin
    trial = {r_in, nq_in[W-1]};
    diff  = trial - {1'b0, d_in};
    ge    = ~diff[W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_out <= 1'b0;
    end else if (en) begin
      v_out <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_out    <= ge ? diff[W-1:0] : trial[W-1:0];
      nq_out   <= {nq_in[W-2:0], ge};
      d_out    <= d_in;
      side_out <= side_in;
    end
  end

endmodule

/* hdl/bsc_divider.sv */
// Unsigned divider built as a row of W step cells.
module bsc_divider import bsc_pkg::*; #(
  parameter int W = PDIV_W,
  parameter type side_t = logic
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic         v_in,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  input  side_t        side_in,
  output logic         v_out,
  output logic [W-1:0] quo,
  output side_t        side_out
);

  logic         v  [0:W];
  logic [W-1:0] r  [0:W];
  logic [W-1:0] nq [0:W];
  logic [W-1:0] d  [0:W];
  side_t        s  [0:W];

  assign v[0]  = v_in;
  assign r[0]  = '0;
  assign nq[0] = num;
  assign d[0]  = den;
  assign s[0]  = side_in;

  for (genvar i = 0; i < W; i++) begin : g_cell
    bsc_div_cell #(.W(W), .side_t(side_t)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .v_in(v[i]), .r_in(r[i]), .nq_in(nq[i]), .d_in(d[i]), .side_in(s[i]),
      .v_out(v[i+1]), .r_out(r[i+1]), .nq_out(nq[i+1]), .d_out(d[i+1]),
      .side_out(s[i+1])
    );
  end

  assign v_out    = v[W];
  assign quo      = nq[W];
  assign side_out = s[W];

endmodule

/* hdl/barometric_sensor_compensation.sv */
// Top level: pipelined barometric temperature and pressure compensation.
//
//  channel  | dir | payload                                   | transfer
//  ---------+-----+-------------------------------------------+------------------
//  sample   | in  | raw_temperature, raw_pressure             | valid && ready
//  result   | out | temperature_tenths, pressure_pa, status   | valid && ready
//  cfg      | in  | cfg_we, cfg_index, cfg_data               | cfg_we high
//
// One reading pair per cycle while the skid entry is empty. The depth is set by
// the two chains of division cells (27 for the temperature quotient, 32 for
// pressure) plus the arithmetic stages and the output register.
// Synchronous reset clears all valid bits and the calibration registers.
// A stall on result fills a one-entry skid behind the output register; the
// whole pipeline holds only while that skid is occupied.
`include "barometric_sensor_compensation_macros.svh"
module barometric_sensor_compensation import bsc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_data,
  bsc_stream_if.sink       sample,
  bsc_stream_if.source     result
);

  // ---------------- configuration registers
  logic [63:0]        temp_cal;
  logic [63:0]        pressure_cal_a;
  logic [31:0]        pressure_cal_b;
  logic [1:0]         oversampling;
  logic signed [16:0] pressure_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_cal        <= '0;
      pressure_cal_a  <= '0;
      pressure_cal_b  <= '0;
      oversampling    <= '0;
      pressure_offset <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TEMP_CAL: temp_cal       <= cfg_data;
        REG_PCAL_A:   pressure_cal_a <= cfg_data;
        REG_PCAL_B:   pressure_cal_b <= cfg_data[31:0];
        REG_OSS:      oversampling   <= cfg_data[1:0];
        REG_P_OFFSET: pressure_offset <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  // calibration words
  logic [31:0]        ac5, ac6, ac4;
  logic signed [31:0] mc, md, ac1, ac2, ac3, b1, b2;
  always_comb begin
    ac5 = {16'd0, temp_cal[15:0]};
    ac6 = {16'd0, temp_cal[31:16]};
    mc  = {{16{temp_cal[47]}}, temp_cal[47:32]};
    md  = {{16{temp_cal[63]}}, temp_cal[63:48]};
    ac1 = {{16{pressure_cal_a[15]}}, pressure_cal_a[15:0]};
    ac2 = {{16{pressure_cal_a[31]}}, pressure_cal_a[31:16]};
    ac3 = {{16{pressure_cal_a[47]}}, pressure_cal_a[47:32]};
    ac4 = {16'd0, pressure_cal_a[63:48]};
    b1  = {{16{pressure_cal_b[15]}}, pressure_cal_b[15:0]};
    b2  = {{16{pressure_cal_b[31]}}, pressure_cal_b[31:16]};
  end

  // global advance: hold only while the skid entry is full
  logic en;
  logic skid_valid;
  assign en           = ~skid_valid;
  assign sample.ready = en;

  // ---------------- P0: capture, oversampling shift
  logic        v0;
  logic [15:0] ut0;
  logic [18:0] up0;
  logic [23:0] up_shift;
  logic [3:0]  shamt;

  always_comb begin
    shamt    = 4'd8 - {2'b00, oversampling};
    up_shift = sample.payload.raw_pressure >> shamt;
  end

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (en) v0 <= sample.valid;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ut0 <= sample.payload.raw_temperature;
      up0 <= up_shift[18:0];
    end
  end

  // ---------------- P1: x1 = ((ut - ac6) * ac5) >> 15
  logic               v1;
  logic signed [16:0] x1_1;
  logic [18:0]        up1;
  logic [31:0]        m_t;
  logic signed [31:0] m_ts;

  always_comb begin
    m_t  = ({16'd0, ut0} - ac6) * ac5;
    m_ts = m_t;
  end

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= v0;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      x1_1 <= m_ts[31:15];
      up1  <= up0;
    end
  end

  // ---------------- P2: divisor x1 + md, sign/magnitude split
  logic               v2;
  logic [TDIV_W-1:0]  tnum2, tden2;
  tdiv_side_t         tside2;
  logic signed [17:0] den;
  logic [17:0]        den_mag;
  logic [TDIV_W-1:0]  num_raw;

  always_comb begin
    den     = {x1_1[16], x1_1} + md[17:0];
    den_mag = den[17] ? 18'(-den) : den;
    num_raw = {mc[15:0], 11'd0};
  end

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      tnum2      <= mc[15] ? TDIV_W'(-num_raw) : num_raw;
      tden2      <= {{(TDIV_W-18){1'b0}}, den_mag};
      tside2.x1  <= x1_1;
      tside2.up  <= up1;
      tside2.neg <= mc[15] ^ den[17];
      tside2.dz  <= (den == 18'sd0);
    end
  end

  // ---------------- temperature divider: (mc*2048) / den
  logic              vtd;
  logic [TDIV_W-1:0] tq;
  tdiv_side_t        tside;

  bsc_divider #(.W(TDIV_W), .side_t(tdiv_side_t)) u_tdiv (
    .clk(clk), .rst(rst), .en(en),
    .v_in(v2), .num(tnum2), .den(tden2), .side_in(tside2),
    .v_out(vtd), .quo(tq), .side_out(tside)
  );

  // ---------------- P3: b5, temperature, b6
  logic               v3;
  logic signed [31:0] b6_3;
  logic signed [15:0] t3;
  logic [18:0]        up3;
  logic               dz3;
  logic signed [31:0] x2t, b5, tb;

  always_comb begin
    x2t = tside.neg ? -$signed({{(32-TDIV_W){1'b0}}, tq})
                    : $signed({{(32-TDIV_W){1'b0}}, tq});
    b5  = $signed({{15{tside.x1[16]}}, tside.x1}) + x2t;
    tb  = (b5 + 32'sd8) >>> 4;
  end

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= vtd;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      b6_3 <= b5 - C_B6_BIAS;
      if (tb > 32'sd32767) t3 <= 16'sd32767;
      else if (tb < -32'sd32768) t3 <= -16'sd32768;
      else t3 <= tb[15:0];
      up3 <= tside.up;
      dz3 <= tside.dz;
    end
  end

  // ---------------- P4: b6 products
  logic               v4;
  logic signed [31:0] msq4, mac2_4, mac3_4;
  logic signed [15:0] t4;
  logic [18:0]        up4;
  logic               dz4;

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      msq4   <= b6_3 * b6_3;
      mac2_4 <= ac2 * b6_3;
      mac3_4 <= ac3 * b6_3;
      t4     <= t3;
      up4    <= up3;
      dz4    <= dz3;
    end
  end

  // ---------------- P5: b6q products with b2 and b1
  logic               v5;
  logic signed [31:0] mb2_5, mb1_5, x2a5, x1c5;
  logic signed [15:0] t5;
  logic [18:0]        up5;
  logic               dz5;
  logic signed [31:0] b6q;

  assign b6q = msq4 >>> 12;

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else if (en) v5 <= v4;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      mb2_5 <= b2 * b6q;
      mb1_5 <= b1 * b6q;
      x2a5  <= mac2_4 >>> 11;
      x1c5  <= mac3_4 >>> 13;
      t5    <= t4;
      up5   <= up4;
      dz5   <= dz4;
    end
  end

  // ---------------- P6: b3 and x3
  logic               v6;
  logic signed [31:0] b3_6, x3_6;
  logic signed [15:0] t6;
  logic [18:0]        up6;
  logic               dz6;
  logic signed [31:0] x3a, b3s, x3s;

  always_comb begin
    x3a = (mb2_5 >>> 11) + x2a5;
    b3s = ((ac1 <<< 2) + x3a) <<< oversampling;
    b3s = b3s + 32'sd2;
    x3s = x1c5 + (mb1_5 >>> 16) + 32'sd2;
  end

  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else if (en) v6 <= v5;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      b3_6 <= b3s >>> 2;
      x3_6 <= x3s >>> 2;
      t6   <= t5;
      up6  <= up5;
      dz6  <= dz5;
    end
  end

  // ---------------- P7: b4 and b7
  logic               v7;
  logic [16:0]        b4_7;
  logic [31:0]        b7_7;
  logic signed [15:0] t7;
  logic               dz7;
  logic [31:0]        m_b4, b4_arg;

  always_comb begin
    b4_arg = x3_6 + C_B4_BIAS;
    m_b4   = ac4 * b4_arg;
  end

  always_ff @(posedge clk) begin
    if (rst) v7 <= 1'b0;
    else if (en) v7 <= v6;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      b4_7 <= m_b4[31:15];
      b7_7 <= ({13'd0, up6} - b3_6) * (C_B7_K >> oversampling);
      t7   <= t6;
      dz7  <= dz6;
    end
  end

  // ---------------- pressure divider: b7*2 / b4, halving the big case
  logic              big7;
  logic [PDIV_W-1:0] pnum7, pden7;
  pdiv_side_t        pside7;
  logic              vpd;
  logic [PDIV_W-1:0] pq;
  pdiv_side_t        pside;

  always_comb begin
    big7       = (b7_7 >= C_B7_BIG);
    pnum7      = big7 ? b7_7 : {b7_7[30:0], 1'b0};
    pden7      = {15'd0, b4_7};
    pside7.t   = t7;
    pside7.dz  = dz7;
    pside7.bz  = (b4_7 == 17'd0);
    pside7.big = big7;
  end

  bsc_divider #(.W(PDIV_W), .side_t(pdiv_side_t)) u_pdiv (
    .clk(clk), .rst(rst), .en(en),
    .v_in(v7), .num(pnum7), .den(pden7), .side_in(pside7),
    .v_out(vpd), .quo(pq), .side_out(pside)
  );

  // ---------------- P9: p, (p>>8)^2 and -7357*p
  logic               v9;
  logic signed [31:0] p9, sq9, mk2_9;
  pdiv_side_t         ps9;
  logic signed [31:0] p, pdiv8;

  always_comb begin
    p     = pside.big ? {pq[30:0], 1'b0} : pq;
    pdiv8 = p >>> 8;
  end

  always_ff @(posedge clk) begin
    if (rst) v9 <= 1'b0;
    else if (en) v9 <= vpd;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      p9    <= p;
      sq9   <= pdiv8 * pdiv8;
      mk2_9 <= C_P_K2 * p;
      ps9   <= pside;
    end
  end

  // ---------------- P10: 3038 * x1
  logic               v10;
  logic signed [31:0] p10, mk1_10, x2_10;
  pdiv_side_t         ps10;

  always_ff @(posedge clk) begin
    if (rst) v10 <= 1'b0;
    else if (en) v10 <= v9;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      p10    <= p9;
      mk1_10 <= sq9 * C_P_K1;
      x2_10  <= mk2_9 >>> 16;
      ps10   <= ps9;
    end
  end

  // ---------------- P11: final correction, offset, saturation
  logic               pv;
  out_item_t          pd;
  logic signed [31:0] corr, comp;
  logic signed [33:0] pa;
  out_item_t          res;

  always_comb begin
    corr = ((mk1_10 >>> 16) + x2_10 + C_P_K3) >>> 4;
    comp = p10 + corr;
    pa   = {{2{comp[31]}}, comp} + {{17{pressure_offset[16]}}, pressure_offset};
    res.temperature_tenths = ps10.t;
    if (ps10.dz) begin
      res.temperature_tenths = '0;
      res.pressure_pa        = '0;
      res.status             = ST_TDIV;
    end else if (ps10.bz) begin
      res.pressure_pa = '0;
      res.status      = ST_BDIV;
    end else begin
      if (pa < 34'sd0) res.pressure_pa = '0;
      else if (pa > C_PA_MAX) res.pressure_pa = '1;
      else res.pressure_pa = pa[19:0];
      res.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) pv <= 1'b0;
    else if (en) pv <= v10;
  end
  always_ff @(posedge clk) begin
    if (en) pd <= res;
  end

  // ---------------- output register with skid entry
  logic      out_valid;
  out_item_t out_data;
  out_item_t skid_data;
  logic      take;

  assign take = pv & en;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !result.ready) begin
      if (take) skid_valid <= 1'b1;
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !result.ready) begin
      if (take) skid_data <= pd;
    end else if (skid_valid) begin
      out_data <= skid_data;
    end else if (take) begin
      out_data <= pd;
    end
  end

  assign result.valid   = out_valid;
  assign result.payload = out_data;

  // ---------------- checks
  `BSC_ASSERT_IMPL(a_skid_behind_out, clk, rst, skid_valid, out_valid)
  `BSC_ASSERT_IMPL(a_skid_blocks_in, clk, rst, skid_valid, !sample.ready)
  `BSC_ASSERT_IMPL(a_tdiv_zero, clk, rst, out_valid && out_data.status == ST_TDIV, out_data.temperature_tenths == 16'sd0 && out_data.pressure_pa == 20'd0)
  `BSC_ASSERT_IMPL(a_bdiv_zero, clk, rst, out_valid && out_data.status == ST_BDIV, out_data.pressure_pa == 20'd0)
  `BSC_ASSERT_NEXT(a_skid_drains, clk, rst, skid_valid && result.ready, !skid_valid && out_valid)

endmodule

/* test/barometric_sensor_compensation_tb.sv */
// Self-checking testbench for the barometric temperature/pressure compensation block.
`timescale 1ns / 100ps
module barometric_sensor_compensation_tb;
  import bsc_pkg::*;

  localparam int          CYCLE_LIMIT   = 400000;
  localparam int          DRAIN_CYCLES  = 90;     // exceeds the pipeline latency
  localparam logic [2:0]  REG_UNMAPPED  = 3'd7;   // index the block must ignore

  // idle profiles: percent of cycles the sender idles / the receiver stalls
  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  logic [2:0]       cfg_index;
  logic [CFG_W-1:0] cfg_data;

  bsc_stream_if #(.payload_t(in_item_t))  sample_ch ();
  bsc_stream_if #(.payload_t(out_item_t)) result_ch ();

  barometric_sensor_compensation dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample_ch),
    .result    (result_ch)
  );

  always #5 clk = ~clk;

  // Shadow copy of the calibration registers, kept in step with every write.
  logic [63:0] shadow_tcal;
  logic [63:0] shadow_pcal_a;
  logic [31:0] shadow_pcal_b;
  logic [1:0]  shadow_oss;
  logic [16:0] shadow_offset;

  out_item_t   pending_readings[$];  // expected compensated readings, oldest first
  int          send_idle_pct;
  int          recv_stall_pct;
  int          error_count;
  int          checked_count;
  int          cycle_count;
  int          status_seen[3];

  // -------------------------------------------------------------------------
  // Compensation predictor: 32-bit wrapping integer arithmetic, arithmetic
  // shifts, truncating division, unsigned b4/b7/quotient.
  // -------------------------------------------------------------------------
  function automatic longint wrap32(longint v);
    int w;
    w = v[31:0];
    return w;
  endfunction

  function automatic out_item_t compensate(in_item_t rd);
    longint    ac1, ac2, ac3, ac4, ac5, ac6, mc, md, b1, b2, offs;
    longint    ut, up, x1, x2, x3, den, b5, b6, b6q, b3, t, p, comp, pa;
    logic [31:0] b4, b7, quot;
    out_item_t o;
    ac5  = longint'(shadow_tcal[15:0]);
    ac6  = longint'(shadow_tcal[31:16]);
    mc   = longint'($signed(shadow_tcal[47:32]));
    md   = longint'($signed(shadow_tcal[63:48]));
    ac1  = longint'($signed(shadow_pcal_a[15:0]));
    ac2  = longint'($signed(shadow_pcal_a[31:16]));
    ac3  = longint'($signed(shadow_pcal_a[47:32]));
    ac4  = longint'(shadow_pcal_a[63:48]);
    b1   = longint'($signed(shadow_pcal_b[15:0]));
    b2   = longint'($signed(shadow_pcal_b[31:16]));
    offs = longint'($signed(shadow_offset));
    o    = '0;

    ut = longint'(rd.raw_temperature);
    up = longint'(rd.raw_pressure) >> (8 - int'(shadow_oss));

    x1  = wrap32((ut - ac6) * ac5) >>> 15;
    den = wrap32(x1 + md);
    if (den == 0) begin
      o.status = ST_TDIV;
      return o;
    end
    x2 = (mc * 2048) / den;   // truncates toward zero
    b5 = wrap32(x1 + x2);

    t = wrap32(b5 + 8) >>> 4;
    if (t > 32767) t = 32767;
    if (t < -32768) t = -32768;
    o.temperature_tenths = t[15:0];

    b6  = wrap32(b5 - 4000);
    b6q = wrap32(b6 * b6) >>> 12;
    x1  = wrap32(b2 * b6q) >>> 11;
    x2  = wrap32(ac2 * b6) >>> 11;
    x3  = wrap32(x1 + x2);
    b3  = wrap32(wrap32(ac1 * 4 + x3) * (longint'(1) << shadow_oss) + 2) >>> 2;
    x1  = wrap32(ac3 * b6) >>> 13;
    x2  = wrap32(b1 * b6q) >>> 16;
    x3  = wrap32(x1 + x2 + 2) >>> 2;
    b4  = ac4[31:0] * (x3[31:0] + 32'd32768);
    b4  = b4 >> 15;
    if (b4 == 0) begin
      o.status = ST_BDIV;
      return o;
    end
    b7 = (up[31:0] - b3[31:0]) * (32'd50000 >> shadow_oss);
    // keep the doubling inside 32 bits, as the datasheet does
    if (b7 < 32'h8000_0000) quot = (b7 << 1) / b4;
    else                    quot = (b7 / b4) << 1;
    p = wrap32(longint'(quot));

    x1   = p >>> 8;
    x1   = wrap32(x1 * x1);
    x1   = wrap32(x1 * 3038) >>> 16;
    x2   = wrap32(-7357 * p) >>> 16;
    comp = wrap32(p + (wrap32(x1 + x2 + 3791) >>> 4));

    pa = comp + offs;
    if (pa < 0) pa = 0;
    if (pa > 1048575) pa = 1048575;
    o.pressure_pa = pa[19:0];
    o.status      = ST_OK;
    return o;
  endfunction

  // -------------------------------------------------------------------------
  // Register writes. Only issued once the pipeline has emptied: wait for all
  // outstanding results, then a latency's worth of cycles.
  // -------------------------------------------------------------------------
  task automatic calibrate(logic [63:0] tcal, logic [63:0] pcal_a, logic [31:0] pcal_b,
                           logic [1:0] oss, logic [16:0] offset);
    sample_ch.valid <= 1'b0;
    wait (pending_readings.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_TEMP_CAL;
    cfg_data  <= tcal;
    @(posedge clk);
    cfg_index <= REG_PCAL_A;
    cfg_data  <= pcal_a;
    @(posedge clk);
    cfg_index <= REG_PCAL_B;
    cfg_data  <= {32'h0, pcal_b};
    @(posedge clk);
    cfg_index <= REG_OSS;
    cfg_data  <= {62'h0, oss};
    @(posedge clk);
    cfg_index <= REG_P_OFFSET;
    cfg_data  <= {47'h0, offset};
    @(posedge clk);
    // unmapped index with junk data: must leave every register alone
    cfg_index <= REG_UNMAPPED;
    cfg_data  <= {$urandom, $urandom};
    @(posedge clk);
    cfg_we        <= 1'b0;
    shadow_tcal   = tcal;
    shadow_pcal_a = pcal_a;
    shadow_pcal_b = pcal_b;
    shadow_oss    = oss;
    shadow_offset = offset;
  endtask

  // Datasheet example calibration, optionally jittered.
  function automatic logic [63:0] pack_tcal(int ac5, int ac6, int mc, int md);
    return {md[15:0], mc[15:0], ac6[15:0], ac5[15:0]};
  endfunction

  function automatic logic [63:0] pack_pcal_a(int ac1, int ac2, int ac3, int ac4);
    return {ac4[15:0], ac3[15:0], ac2[15:0], ac1[15:0]};
  endfunction

  function automatic logic [31:0] pack_pcal_b(int b1, int b2);
    return {b2[15:0], b1[15:0]};
  endfunction

  function automatic int jitter(int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  task automatic calibrate_random(logic [1:0] oss);
    logic [16:0] offset;
    offset = 17'($urandom);
    if ($urandom_range(3) == 0) offset = 17'h0;
    if ($urandom_range(3) == 0) begin
      // arbitrary words: exercises wrap, saturation and the divisor-zero paths
      calibrate({$urandom, $urandom}, {$urandom, $urandom}, $urandom, oss, offset);
    end else begin
      calibrate(pack_tcal(32757 + jitter(3000), 23153 + jitter(3000),
                          -8711 + jitter(2000), 2868 + jitter(800)),
                pack_pcal_a(408 + jitter(3000), -72 + jitter(1000),
                            -14383 + jitter(3000), 32741 + jitter(3000)),
                pack_pcal_b(6190 + jitter(1500), 4 + jitter(4)),
                oss, offset);
    end
  endtask

  // -------------------------------------------------------------------------
  // Sender: one transfer per call. valid stays high into the next call when
  // there is no idle cycle, so back-to-back transfers need no extra NBA.
  // -------------------------------------------------------------------------
  task automatic send_reading(logic [15:0] ut, logic [23:0] up);
    in_item_t rd;
    rd.raw_temperature = ut;
    rd.raw_pressure    = up;
    if ($urandom_range(99) < send_idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    sample_ch.valid   <= 1'b1;
    sample_ch.payload <= rd;
    @(posedge clk);
    while (!sample_ch.ready) @(posedge clk);
    pending_readings.push_back(compensate(rd));
  endtask

  task automatic send_realistic();
    logic [15:0] ut;
    logic [23:0] up;
    if ($urandom_range(3) == 0) begin
      ut = 16'($urandom);
      up = 24'($urandom);
    end else begin
      ut = 16'(27898 + jitter(8000));
      up = 24'((23843 + jitter(12000)) << (8 - int'(shadow_oss)));
      up = up | 24'($urandom & ((32'h1 << (8 - int'(shadow_oss))) - 1));
    end
    send_reading(ut, up);
  endtask

  task automatic stop_sending();
    sample_ch.valid <= 1'b0;
  endtask

  // -------------------------------------------------------------------------
  // Receiver: random backpressure per the current profile.
  // -------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result checker: compare every output transfer with the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_readings.size() == 0) begin
        $display("%0t: unexpected result %p", $time, result_ch.payload);
        error_count++;
      end else begin
        want = pending_readings.pop_front();
        checked_count++;
        if (want.status <= ST_BDIV) status_seen[want.status]++;
        if (result_ch.payload.temperature_tenths !== want.temperature_tenths) begin
          $display("%0t: temperature_tenths expected %0d got %0d", $time,
                   want.temperature_tenths, result_ch.payload.temperature_tenths);
          error_count++;
        end
        if (result_ch.payload.pressure_pa !== want.pressure_pa) begin
          $display("%0t: pressure_pa expected %0d got %0d", $time,
                   want.pressure_pa, result_ch.payload.pressure_pa);
          error_count++;
        end
        if (result_ch.payload.status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time,
                   want.status, result_ch.payload.status);
          error_count++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_readings.size());
      $display("** barometric_sensor_compensation: FAILED **");
      $finish;
    end
  end

  task automatic set_idle(idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SEND: begin send_idle_pct = 76; recv_stall_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 76; end
      default:   begin send_idle_pct = 27; recv_stall_pct = 27; end
    endcase
  endtask

  // -------------------------------------------------------------------------
  // Tests
  // -------------------------------------------------------------------------

  // After reset all calibration is zero: md + x1 == 0, temperature divisor zero.
  task automatic test_reset_defaults();
    send_reading(16'h0000, 24'h000000);
    send_reading(16'hFFFF, 24'hFFFFFF);
  endtask

  // Datasheet calibration and reading, every oversampling setting, field extremes.
  task automatic test_datasheet_example();
    for (int oss = 0; oss < 4; oss++) begin
      calibrate(pack_tcal(32757, 23153, -8711, 2868),
                pack_pcal_a(408, -72, -14383, 32741),
                pack_pcal_b(6190, 4), oss[1:0], 17'h0);
      send_reading(16'd27898, 24'(23843 << (8 - oss)));
      send_reading(16'h0000, 24'h000000);
      send_reading(16'hFFFF, 24'hFFFFFF);
    end
  endtask

  // Offset extremes: drives pressure saturation at both ends.
  task automatic test_offset_saturation();
    calibrate(pack_tcal(32757, 23153, -8711, 2868), pack_pcal_a(408, -72, -14383, 32741),
              pack_pcal_b(6190, 4), 2'd3, 17'h10000);  // most negative offset
    send_reading(16'd27898, 24'h000100);
    send_reading(16'd27898, 24'h5D2300);
    calibrate(pack_tcal(32757, 23153, -8711, 2868), pack_pcal_a(408, -72, -14383, 32741),
              pack_pcal_b(6190, 4), 2'd3, 17'h0FFFF);  // most positive offset
    send_reading(16'd27898, 24'hFFFFFF);
    send_reading(16'd27898, 24'h000000);
  endtask

  // ac4 zero forces b4 zero: valid temperature, zero pressure.
  // Huge mc / tiny md push temperature into saturation.
  task automatic test_divisor_and_extremes();
    calibrate(pack_tcal(32757, 23153, -8711, 2868), pack_pcal_a(408, -72, -14383, 0),
              pack_pcal_b(6190, 4), 2'd0, 17'h0);
    send_reading(16'd27898, 24'h5D2300);
    send_reading(16'hFFFF, 24'hFFFFFF);
    calibrate(pack_tcal(65535, 0, 32767, 1), pack_pcal_a(-32768, 32767, -32768, 65535),
              pack_pcal_b(-32768, 32767), 2'd1, 17'h0);
    send_reading(16'hFFFF, 24'hFFFFFF);
    send_reading(16'h0000, 24'h800000);
    calibrate(pack_tcal(65535, 65535, -32768, 1), pack_pcal_a(32767, -32768, 32767, 65535),
              pack_pcal_b(32767, -32768), 2'd2, 17'h0);
    send_reading(16'h0000, 24'h000000);
    send_reading(16'h8000, 24'hFFFFFF);
  endtask

  // Random calibration per phase, each idle profile in turn.
  task automatic test_random_phases();
    idle_mode_t modes[4] = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH};
    for (int ph = 0; ph < 8; ph++) begin
      calibrate_random(2'(ph % 4));
      set_idle(modes[ph % 4]);
      for (int n = 0; n < 100; n++) send_realistic();
      stop_sending();
    end
    set_idle(IDLE_NONE);
  endtask

  initial begin
    rst               = 1'b1;
    cfg_we            <= 1'b0;
    cfg_index         <= REG_TEMP_CAL;
    cfg_data          <= '0;
    sample_ch.valid   <= 1'b0;
    sample_ch.payload <= '0;
    shadow_tcal       = '0;
    shadow_pcal_a     = '0;
    shadow_pcal_b     = '0;
    shadow_oss        = '0;
    shadow_offset     = '0;
    error_count       = 0;
    checked_count     = 0;
    cycle_count       = 0;
    set_idle(IDLE_NONE);
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_datasheet_example();
    test_offset_saturation();
    test_divisor_and_extremes();
    stop_sending();
    test_random_phases();

    wait (pending_readings.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d compensated readings: %0d ok, %0d temperature-divisor-zero, %0d b4-zero",
             checked_count, status_seen[ST_OK], status_seen[ST_TDIV], status_seen[ST_BDIV]);
    $display("Covered all oversampling settings, offset extremes and four idle/stall profiles");
    if (error_count == 0) begin
      $display("** barometric_sensor_compensation: PASSED **");
    end else begin
      $display("** barometric_sensor_compensation: FAILED **");
    end
    $finish;
  end

endmodule
